// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

`endif

// File: rtl/core/fpcv_pkg.sv
// Shared types and constants for the binary32/binary16 converter.
// No dependencies.
package fpcv_pkg;

  typedef enum logic [1:0] {
    ACT_PACK     = 2'd0,
    ACT_UNPACK   = 2'd1,
    ACT_TRUNCATE = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  localparam logic [15:0] HALF_QNAN      = 16'h7e00;
  localparam logic [14:0] HALF_INF_MAG   = 15'h7c00;
  localparam logic [14:0] HALF_MAX_MAG   = 15'h7bff;
  localparam logic [31:0] FLOAT_QNAN     = 32'h7fc00000;
  localparam logic [30:0] FLOAT_INF_MAG  = 31'h7f800000;
  localparam logic [23:0] ROUND_BIAS     = 24'h001000;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctrl_t;

endpackage

// File: rtl/core/fpcv_convert.sv
// Combinational pack, unpack and truncate conversion between binary32 and binary16.
// Depends on fpcv_pkg.
module fpcv_convert (
  input  fpcv_pkg::action_t action,
  input  logic [31:0]       operand_bits,
  output logic [31:0]       result_bits
);
  import fpcv_pkg::*;

  function automatic logic [15:0] pack_half(input logic [31:0] bits);
    logic        sign;
    logic [7:0]  efield;
    logic [22:0] frac;
    logic [3:0]  sh;
    logic [23:0] sub;
    logic [24:0] sub_rnd;
    logic [23:0] nrm;
    logic [4:0]  e;
    logic [15:0] h;
    sign    = bits[31];
    efield  = bits[30:23];
    frac    = bits[22:0];
    sh      = 4'(8'd113 - efield);
    sub     = {1'b1, frac} >> sh;
    sub_rnd = {1'b0, sub} + {1'b0, ROUND_BIAS};
    nrm     = {1'b0, frac} + ROUND_BIAS;
    e       = 5'(efield - 8'd112);
    if (efield == 8'hff) begin
      h = (frac != '0) ? HALF_QNAN : {sign, HALF_INF_MAG};
    end else if (efield <= 8'd112) begin
      if (efield < 8'd102) begin
        h = {sign, 15'd0};
      end else begin
        h = {sign, 3'd0, sub_rnd[24:13]};
      end
    end else if (efield >= 8'd143) begin
      h = {sign, HALF_INF_MAG};
    end else if (nrm[23]) begin
      if (efield == 8'd142) begin
        h = {sign, HALF_INF_MAG};
      end else begin
        h = {sign, e + 5'd1, 10'd0};
      end
    end else begin
      h = {sign, e, nrm[22:13]};
    end
    return h;
  endfunction

  function automatic logic [31:0] unpack_half(input logic [15:0] h);
    logic        sign;
    logic [4:0]  e;
    logic [9:0]  frac;
    logic [3:0]  p;
    logic [22:0] m;
    logic [31:0] r;
    sign = h[15];
    e    = h[14:10];
    frac = h[9:0];
    p    = '0;
    for (int i = 0; i < 10; i++) begin
      if (frac[i]) begin
        p = 4'(i);
      end
    end
    m = {13'd0, frac} << (5'd23 - {1'b0, p});
    if (e == 5'd0) begin
      if (frac == '0) begin
        r = {sign, 31'd0};
      end else begin
        r = {sign, 8'({4'd0, p} + 8'd103), m};
      end
    end else if (e == 5'h1f) begin
      r = (frac != '0) ? FLOAT_QNAN : {sign, FLOAT_INF_MAG};
    end else begin
      r = {sign, 8'({3'd0, e} + 8'd112), frac, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] truncate_half(input logic [31:0] bits);
    logic        sign;
    logic [7:0]  efield;
    logic [22:0] frac;
    logic [3:0]  sh;
    logic [23:0] sub;
    logic [15:0] h;
    logic [31:0] r;
    sign   = bits[31];
    efield = bits[30:23];
    frac   = bits[22:0];
    sh     = 4'(8'd113 - efield);
    sub    = {1'b1, frac} >> sh;
    if (efield >= 8'd143) begin
      h = {sign, HALF_MAX_MAG};
    end else if (efield <= 8'd112) begin
      h = (efield < 8'd102) ? {sign, 15'd0} : {sign, 5'd0, sub[22:13]};
    end else begin
      h = {sign, 5'(efield - 8'd112), frac[22:13]};
    end
    if (efield == 8'hff) begin
      r = (frac != '0) ? FLOAT_QNAN : {sign, FLOAT_INF_MAG};
    end else begin
      r = unpack_half(h);
    end
    return r;
  endfunction

  always_comb begin
    case (action)
      ACT_PACK:     result_bits = {16'd0, pack_half(operand_bits)};
      ACT_UNPACK:   result_bits = unpack_half(operand_bits[15:0]);
      ACT_TRUNCATE: result_bits = truncate_half(operand_bits);
      default:      result_bits = '0;
    endcase
  end

endmodule

// File: rtl/core/fpcv_ctrl.sv
// Valid tracking and load enables for the input and result register stages.
// Depends on fpcv_pkg.
module fpcv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fpcv_pkg::pipe_ctrl_t ctrl
);
  import fpcv_pkg::*;

  logic s1_valid;
  logic s2_valid;
  logic s2_free;
  logic s1_free;

  assign s2_free      = !s2_valid || !out_stall;
  assign s1_free      = !s1_valid || s2_free;
  assign in_stall     = !s1_free;
  assign out_valid    = s2_valid;
  assign ctrl.s1_load = in_valid && s1_free;
  assign ctrl.s2_load = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

endmodule

// File: rtl/core/fp32_fp16_converter.sv
// Top level of the binary32/binary16 converter: input register, conversion logic, result register.
// Depends on fpcv_pkg, fpcv_ctrl and fpcv_convert.
//
// Converts raw bit patterns: action 0 packs binary32 to binary16 (half-unit rounding, ties
// away from zero, NaN to 0x7e00, result in the low 16 bits), action 1 unpacks binary16 in the
// low 16 bits to binary32 exactly, action 2 truncates binary32 to binary16 and widens it back,
// action 3 returns zero. One operand is taken every cycle while in_stall is low; it is held
// in the input register and converted, and the result register loads the result once the
// result stage is free. Stall on the result side holds both stages and then the input.
module fp32_fp16_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);
  import fpcv_pkg::*;

  pipe_ctrl_t  ctrl;
  action_t     s1_action;
  logic [31:0] s1_operand;
  logic [31:0] conv_result;
  logic [31:0] s2_result;

  fpcv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  fpcv_convert u_convert (
    .action       (s1_action),
    .operand_bits (s1_operand),
    .result_bits  (conv_result)
  );

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      s1_action  <= action_t'(action);
      s1_operand <= operand_bits;
    end
    if (ctrl.s2_load) begin
      s2_result <= conv_result;
    end
  end

  assign result_bits = s2_result;

endmodule

// File: rtl/core/fpcv_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on fpcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpcv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_bits
);
  import fpcv_pkg::*;

  logic in_xfer;
  logic unused_xfer;
  logic pack_xfer;
  logic result_zero;
  logic upper_zero;

  assign in_xfer     = in_valid && !in_stall;
  assign unused_xfer = in_xfer && (action == ACT_UNUSED);
  assign pack_xfer   = in_xfer && (action == ACT_PACK);
  assign result_zero = (result_bits == 32'd0);
  assign upper_zero  = (result_bits[31:16] == 16'd0);

  `ASSERT_NEXT(hold_valid, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(hold_result, clk, rst, out_valid && out_stall, $stable(result_bits))
  `ASSERT_NEXT(deliver_after_transfer, clk, rst, in_xfer ##1 !out_stall, out_valid)
  `ASSERT_NEXT(unused_gives_zero, clk, rst, unused_xfer ##1 !out_stall, out_valid && result_zero)
  `ASSERT_NEXT(pack_upper_zero, clk, rst, pack_xfer ##1 !out_stall, out_valid && upper_zero)

endmodule

bind fp32_fp16_converter fpcv_checker u_fpcv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .action       (action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_bits  (result_bits)
);

// File: tb/fp32_fp16_converter_tb.sv
// Self-checking testbench for fp32_fp16_converter: directed special values, then random
// pack / unpack / truncate traffic under bursty input and patterned output stall.
// Depends on fpcv_pkg and the fp32_fp16_converter RTL.
module fp32_fp16_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpcv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef struct {
    action_t     act;
    logic [31:0] operand;
    logic [31:0] expected;
  } conversion_t;

  class conversion_scoreboard;
    conversion_t pending_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned per_action[4];

    function automatic logic [31:0] unpack_half(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [9:0]  fr;
      int          p;
      sgn = {h[15], 31'b0};
      ex  = h[14:10];
      fr  = h[9:0];
      if (ex == 5'd0) begin
        if (fr == 10'd0) return sgn;
        p = 9;
        while (p > 0 && !fr[p]) p--;
        return sgn | (32'(p + 103) << 23) | ((32'(fr) << (23 - p)) & 32'h007fffff);
      end
      if (ex == 5'h1f) begin
        if (fr != 10'd0) return FLOAT_QNAN;
        return {h[15], FLOAT_INF_MAG};
      end
      return sgn | ((32'(ex) + 32'd112) << 23) | (32'(fr) << 13);
    endfunction

    function automatic logic [31:0] pack_half(logic [31:0] b);
      logic [15:0] sgn;
      logic [7:0]  ef;
      logic [31:0] t;
      int          e;
      sgn = {b[31], 15'b0};
      ef  = b[30:23];
      e   = int'(ef) - 112;
      if (ef == 8'hff) begin
        if (b[22:0] != 23'd0) return {16'b0, HALF_QNAN};
        return {16'b0, b[31], HALF_INF_MAG};
      end
      if (e <= 0) begin
        if (e < -10) return {16'b0, sgn};
        t = {8'b0, 1'b1, b[22:0]} >> (1 - e);
        return {16'b0, sgn | 16'((t + 32'(ROUND_BIAS)) >> 13)};
      end
      if (e >= 31) return {16'b0, b[31], HALF_INF_MAG};
      t = {9'b0, b[22:0]} + 32'(ROUND_BIAS);
      if (t[23]) begin
        t = 32'd0;
        e++;
        if (e >= 31) return {16'b0, b[31], HALF_INF_MAG};
      end
      return {16'b0, sgn | (16'(e) << 10) | 16'(t >> 13)};
    endfunction

    function automatic logic [31:0] truncate_half(logic [31:0] b);
      logic [15:0] sgn;
      logic [15:0] h;
      logic [7:0]  ef;
      int          e;
      sgn = {b[31], 15'b0};
      ef  = b[30:23];
      e   = int'(ef) - 112;
      if (ef == 8'hff) begin
        if (b[22:0] != 23'd0) return FLOAT_QNAN;
        return {b[31], FLOAT_INF_MAG};
      end
      if (e >= 31) begin
        h = {b[31], HALF_MAX_MAG};
      end else if (e <= 0) begin
        if (e < -10) h = sgn;
        else h = sgn | 16'(({8'b0, 1'b1, b[22:0]} >> (1 - e)) >> 13);
      end else begin
        h = sgn | (16'(e) << 10) | 16'(b[22:0] >> 13);
      end
      return unpack_half(h);
    endfunction

    function automatic logic [31:0] convert_operand(action_t act, logic [31:0] b);
      case (act)
        ACT_PACK:     return pack_half(b);
        ACT_UNPACK:   return unpack_half(b[15:0]);
        ACT_TRUNCATE: return truncate_half(b);
        default:      return 32'd0;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    function void note_operand(action_t act, logic [31:0] b);
      conversion_t c;
      c.act      = act;
      c.operand  = b;
      c.expected = convert_operand(act, b);
      pending_results.push_back(c);
      per_action[act]++;
    endfunction

    task check_result(logic [31:0] got);
      conversion_t c;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no transfer pending", got));
      end else begin
        c = pending_results.pop_front();
        checked++;
        if (got !== c.expected)
          report_mismatch($sformatf("%s %h: result_bits %h, want %h",
                                    c.act.name(), c.operand, got, c.expected));
      end
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_PACK;
  logic [31:0] operand_bits = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_bits;

  conversion_scoreboard sb = new();
  int unsigned cycle_count = 0;

  fp32_fp16_converter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .operand_bits (operand_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_bits  (result_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
    $display("fp32_fp16_converter_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result_bits);
  end

  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_run = 0;

  always @(negedge clk) begin
    logic next_stall;
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    next_stall = 1'b0;
    case (stall_mode)
      0: next_stall = 1'b0;
      1: next_stall = ($urandom_range(0, 99) < 35);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          next_stall = 1'b1;
        end else if ($urandom_range(0, 99) < 12) begin
          stall_run = $urandom_range(0, 7);
          next_stall = 1'b1;
        end
      end
    endcase
    out_stall <= next_stall;
  end

  task automatic send_item(action_t act, logic [31:0] b);
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    operand_bits <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_operand(act, b);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4: b[30:23] = 8'($urandom_range(100, 145));
      5: begin
        b[30:23] = 8'($urandom_range(98, 142));
        b[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
      end
      6: begin
        b[30:23] = 8'($urandom_range(141, 143));
        b[22:16] = 7'h7f;
      end
      7: begin
        b[30:23] = 8'hff;
        if ($urandom_range(0, 1)) b[22:0] = 23'd0;
      end
      8: begin
        b[30:23] = 8'd0;
        if ($urandom_range(0, 1)) b[22:0] = 23'd0;
      end
      default: begin
        b[30:23] = 8'($urandom_range(98, 142));
        b[22:12] = 11'h7ff;
      end
    endcase
    return b;
  endfunction

  function automatic logic [31:0] random_half();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 5))
      0: b[14:10] = 5'd0;
      1: begin
        b[14:10] = 5'h1f;
        if ($urandom_range(0, 1)) b[9:0] = 10'd0;
      end
      2: b[14:0] = 15'd0;
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned pct;
    bit          drained_mid;
    action_t     act;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(ACT_PACK, 32'h00000000);
    send_item(ACT_PACK, 32'h80000000);
    send_item(ACT_PACK, 32'h3f800000);
    send_item(ACT_PACK, 32'h3f801000);
    send_item(ACT_PACK, 32'h3ffff000);
    send_item(ACT_PACK, 32'h477fe000);
    send_item(ACT_PACK, 32'hc77ff000);
    send_item(ACT_PACK, 32'h7f800000);
    send_item(ACT_PACK, 32'hff800000);
    send_item(ACT_PACK, 32'hffffffff);
    send_item(ACT_PACK, 32'h33800000);
    send_item(ACT_PACK, 32'hb3000000);
    send_item(ACT_PACK, 32'h387ff000);
    send_item(ACT_UNPACK, 32'h00000000);
    send_item(ACT_UNPACK, 32'hffff8000);
    send_item(ACT_UNPACK, 32'h00000001);
    send_item(ACT_UNPACK, 32'h000083ff);
    send_item(ACT_UNPACK, 32'h0000fc00);
    send_item(ACT_UNPACK, 32'h0000fe01);
    send_item(ACT_UNPACK, 32'habcd3c00);
    send_item(ACT_TRUNCATE, 32'h7f7fffff);
    send_item(ACT_TRUNCATE, 32'hff800000);
    send_item(ACT_TRUNCATE, 32'h7fa00000);
    send_item(ACT_TRUNCATE, 32'hb3ffffff);
    send_item(ACT_UNUSED, 32'hdeadbeef);
    drain_results();

    sent = 0;
    drained_mid = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pct = $urandom_range(0, 99);
        if (pct < 32) act = ACT_PACK;
        else if (pct < 64) act = ACT_UNPACK;
        else if (pct < 96) act = ACT_TRUNCATE;
        else act = ACT_UNUSED;
        send_item(act, (act == ACT_UNPACK) ? random_half() : random_float());
        sent++;
      end
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end else if ($urandom_range(0, 99) >= 40) begin
        idle_cycles($urandom_range(1, 8));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("transfers: pack %0d, unpack %0d, truncate %0d, unused %0d",
             sb.per_action[ACT_PACK], sb.per_action[ACT_UNPACK],
             sb.per_action[ACT_TRUNCATE], sb.per_action[ACT_UNUSED]);
    $display("results checked %0d in %0d cycles, mismatches %0d",
             sb.checked, cycle_count, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fp32_fp16_converter_tb: done, clean");
    end else begin
      $display("fp32_fp16_converter_tb: done, errors");
    end
    $finish;
  end
endmodule
